// ===== rtl/core/multi_zone_clock_with_zone_editor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-zone clock.
// Clock and reset are taken from the enclosing module (clk, rst_n).
// ----------------------------------------------------------------------------
`ifndef MULTI_ZONE_CLOCK_WITH_ZONE_EDITOR_UNIT_MACROS_SVH
`define MULTI_ZONE_CLOCK_WITH_ZONE_EDITOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define MZC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mzc assertion failed");

// Next-cycle implication.
`define MZC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mzc assertion failed");

`endif

// ===== rtl/core/mzc_pkg.sv =====
// ----------------------------------------------------------------------------
// mzc_pkg
// Types, codes and constants shared by the multi-zone clock modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mzc_pkg;

    typedef enum logic [2:0] {
        FN_TICK     = 3'd0,
        FN_UP       = 3'd1,
        FN_DOWN     = 3'd2,
        FN_LEFT     = 3'd3,
        FN_RIGHT    = 3'd4,
        FN_SET_TIME = 3'd5,
        FN_SET_ZONE = 3'd6
    } func_t;

    localparam logic [6:0] CH_A = 7'd65;
    localparam logic [6:0] CH_Z = 7'd90;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [5:0] MIN_WRAP  = 6'd60;
    localparam logic [4:0] HOUR_LAST = 5'd23;
    localparam logic [4:0] HOUR_WRAP = 5'd24;

    // cursor positions
    localparam logic [1:0] CUR_LETTER_ONE = 2'd0;
    localparam logic [1:0] CUR_LETTER_TWO = 2'd1;
    localparam logic [1:0] CUR_OFFSET     = 2'd2;

    typedef struct packed {
        func_t      func;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [1:0] load_zone;
        logic [6:0] load_letter_one;
        logic [6:0] load_letter_two;
        logic [4:0] load_offset;
    } item_t;

    typedef struct packed {
        logic [1:0] shown_zone;
        logic [6:0] name_first;
        logic [6:0] name_second;
        logic [4:0] local_hour;
        logic [5:0] shown_minute;
        logic [5:0] shown_second;
        logic       editing;
        logic [1:0] cursor_field;
    } result_t;

    // out-of-range letters are stored as 'A'
    function automatic logic [6:0] letter_ok(input logic [6:0] c);
        return (c >= CH_A && c <= CH_Z) ? c : CH_A;
    endfunction

    // zones 0..3 start as AA, BB, CC, DD; the rest as AA
    function automatic logic [6:0] reset_letter(input int idx);
        return (idx < 4) ? 7'(int'(CH_A) + idx) : CH_A;
    endfunction

endpackage

// ===== rtl/core/mzc_engine.sv =====
// ----------------------------------------------------------------------------
// mzc_engine
// Clock and zone state; applies one request per enabled cycle and presents
// the display result computed from the updated state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mzc_engine #(
    parameter int ZONE_COUNT = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  mzc_pkg::item_t  item,
    output mzc_pkg::result_t result
);
    import mzc_pkg::*;

    localparam int ZW = $clog2(ZONE_COUNT);
    localparam logic [ZW-1:0] ZONE_LAST = ZW'(ZONE_COUNT - 1);

    logic [5:0]    sec_reg,  sec_next;
    logic [5:0]    min_reg,  min_next;
    logic [4:0]    hour_reg, hour_next;
    logic [ZW-1:0] zone_reg, zone_next;
    logic          edit_reg, edit_next;
    logic [1:0]    cursor_reg, cursor_next;
    logic [6:0]    letter_one_reg [ZONE_COUNT];
    logic [6:0]    letter_one_next[ZONE_COUNT];
    logic [6:0]    letter_two_reg [ZONE_COUNT];
    logic [6:0]    letter_two_next[ZONE_COUNT];
    logic [4:0]    offset_reg     [ZONE_COUNT];
    logic [4:0]    offset_next    [ZONE_COUNT];

    logic [ZW+1:0] load_idx;
    logic [6:0]    cur_letter;
    logic [6:0]    new_letter;
    logic [4:0]    cur_offset;
    logic [4:0]    new_offset;
    logic [5:0]    hour_sum;
    logic          up;

    assign load_idx = (ZW+2)'(item.load_zone);
    assign up       = (item.func == FN_UP);

    // letter or offset under the cursor, stepped
    always_comb
    begin
        cur_letter = (cursor_reg == CUR_LETTER_ONE) ? letter_one_reg[zone_reg]
                                                    : letter_two_reg[zone_reg];
        cur_offset = offset_reg[zone_reg];
        if (up)
        begin
            new_letter = (cur_letter >= CH_Z) ? CH_A : cur_letter + 7'd1;
            new_offset = (cur_offset >= HOUR_LAST) ? 5'd0 : cur_offset + 5'd1;
        end
        else
        begin
            new_letter = (cur_letter <= CH_A) ? CH_Z : cur_letter - 7'd1;
            new_offset = (cur_offset == 5'd0) ? HOUR_LAST : cur_offset - 5'd1;
        end
    end

    always_comb
    begin
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        zone_next       = zone_reg;
        edit_next       = edit_reg;
        cursor_next     = cursor_reg;
        letter_one_next = letter_one_reg;
        letter_two_next = letter_two_reg;
        offset_next     = offset_reg;
        case (item.func)
            FN_TICK:
            begin
                if (sec_reg >= SEC_LAST)
                begin
                    sec_next = 6'd0;
                    if (min_reg >= MIN_LAST)
                    begin
                        min_next  = 6'd0;
                        hour_next = (hour_reg >= HOUR_LAST) ? 5'd0 : hour_reg + 5'd1;
                    end
                    else
                        min_next = min_reg + 6'd1;
                end
                else
                    sec_next = sec_reg + 6'd1;
            end
            FN_UP, FN_DOWN:
            begin
                if (edit_reg)
                begin
                    if (cursor_reg == CUR_LETTER_ONE)
                        letter_one_next[zone_reg] = new_letter;
                    else if (cursor_reg == CUR_LETTER_TWO)
                        letter_two_next[zone_reg] = new_letter;
                    else
                        offset_next[zone_reg] = new_offset;
                end
                else if (up)
                    zone_next = (zone_reg >= ZONE_LAST) ? '0 : zone_reg + ZW'(1);
                else
                    zone_next = (zone_reg == '0) ? ZONE_LAST : zone_reg - ZW'(1);
            end
            FN_LEFT:
            begin
                if (edit_reg && cursor_reg != CUR_LETTER_ONE)
                    cursor_next = cursor_reg - 2'd1;
            end
            FN_RIGHT:
            begin
                if (!edit_reg)
                begin
                    edit_next   = 1'b1;
                    cursor_next = CUR_LETTER_ONE;
                end
                else if (cursor_reg >= CUR_OFFSET)
                begin
                    edit_next   = 1'b0;
                    cursor_next = CUR_LETTER_ONE;
                end
                else
                    cursor_next = cursor_reg + 2'd1;
            end
            FN_SET_TIME:
            begin
                hour_next = (item.set_hour >= HOUR_WRAP) ? item.set_hour - HOUR_WRAP
                                                         : item.set_hour;
                min_next  = (item.set_minute >= MIN_WRAP) ? item.set_minute - MIN_WRAP
                                                          : item.set_minute;
                sec_next  = 6'd0;
            end
            FN_SET_ZONE:
            begin
                if (load_idx < (ZW+2)'(ZONE_COUNT))
                begin
                    letter_one_next[load_idx[ZW-1:0]] = letter_ok(item.load_letter_one);
                    letter_two_next[load_idx[ZW-1:0]] = letter_ok(item.load_letter_two);
                    offset_next[load_idx[ZW-1:0]] =
                        (item.load_offset >= HOUR_WRAP) ? item.load_offset - HOUR_WRAP
                                                        : item.load_offset;
                end
            end
            default:
            begin
            end
        endcase
    end

    // display from the updated state
    always_comb
    begin
        hour_sum             = {1'b0, hour_next} + {1'b0, offset_next[zone_next]};
        result.shown_zone    = 2'(zone_next);
        result.name_first    = letter_one_next[zone_next];
        result.name_second   = letter_two_next[zone_next];
        result.local_hour    = (hour_sum >= 6'(HOUR_WRAP)) ? 5'(hour_sum - 6'(HOUR_WRAP))
                                                           : hour_sum[4:0];
        result.shown_minute  = min_next;
        result.shown_second  = sec_next;
        result.editing       = edit_next;
        result.cursor_field  = edit_next ? cursor_next : CUR_LETTER_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg    <= 6'd0;
            min_reg    <= 6'd0;
            hour_reg   <= 5'd0;
            zone_reg   <= '0;
            edit_reg   <= 1'b0;
            cursor_reg <= CUR_LETTER_ONE;
            for (int i = 0; i < ZONE_COUNT; i++)
            begin
                letter_one_reg[i] <= reset_letter(i);
                letter_two_reg[i] <= reset_letter(i);
                offset_reg[i]     <= 5'd0;
            end
        end
        else if (en)
        begin
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
            zone_reg       <= zone_next;
            edit_reg       <= edit_next;
            cursor_reg     <= cursor_next;
            letter_one_reg <= letter_one_next;
            letter_two_reg <= letter_two_next;
            offset_reg     <= offset_next;
        end
    end

endmodule

// ===== rtl/core/multi_zone_clock_with_zone_editor_unit.sv =====
// ----------------------------------------------------------------------------
// multi_zone_clock_with_zone_editor_unit
// Reference clock with ZONE_COUNT named, hour-offset zones and a zone editor.
// ----------------------------------------------------------------------------
// Every request (tick, button, or load) produces exactly one result that
// describes the display after the request took effect: shown zone, its
// two-letter name, local hour, minute, second and editor status. The block
// takes one request per clock cycle while s_tready is high; a request waits in the input
// register until the result register can take a new value, then its result is
// registered there and m_tvalid rises; a stall on m_tready can hold it in the
// input register. The input register and the result register keep the two
// sides apart: a new request is still taken while a result waits for m_tready,
// and only when both registers are full does s_tready drop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_zone_clock_with_zone_editor_unit_macros.svh"

module multi_zone_clock_with_zone_editor_unit #(
    parameter int ZONE_COUNT = 4    // 2 to 4 zones
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    // set_hour[4:0], set_minute[10:5], load_zone[12:11],
    // load_letter_one[19:13], load_letter_two[26:20], load_offset[31:27]
    input  logic [31:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    // shown_zone[1:0], name_first[8:2], name_second[15:9], local_hour[20:16],
    // shown_minute[26:21], shown_second[32:27], editing[33],
    // cursor_field[35:34], zero[39:36]
    output logic [39:0] m_tdata
);
    import mzc_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    result_t result;

    logic    s_accept;
    logic    advance;   // result register can take a new value
    logic    fire;      // request leaves input register, state updates

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.func            <= func_t'(s_tuser);
            in_item_reg.set_hour        <= s_tdata[4:0];
            in_item_reg.set_minute      <= s_tdata[10:5];
            in_item_reg.load_zone       <= s_tdata[12:11];
            in_item_reg.load_letter_one <= s_tdata[19:13];
            in_item_reg.load_letter_two <= s_tdata[26:20];
            in_item_reg.load_offset     <= s_tdata[31:27];
        end
        if (fire)
            out_result_reg <= result;
    end

    mzc_engine #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (fire),
        .item   (in_item_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_result_reg.cursor_field,
                       out_result_reg.editing,
                       out_result_reg.shown_second,
                       out_result_reg.shown_minute,
                       out_result_reg.local_hour,
                       out_result_reg.name_second,
                       out_result_reg.name_first,
                       out_result_reg.shown_zone};

    // Time fields of a presented result stay in range.
    `MZC_ASSERT_NOW(a_time_range, out_valid_reg, out_result_reg.local_hour < HOUR_WRAP && out_result_reg.shown_minute < MIN_WRAP && out_result_reg.shown_second <= SEC_LAST)
    // Cursor reads zero outside the editor.
    `MZC_ASSERT_NOW(a_cursor_view, out_valid_reg && !out_result_reg.editing, out_result_reg.cursor_field == CUR_LETTER_ONE)
    // Backpressure only when both registers are occupied and the sink stalls.
    `MZC_ASSERT_NOW(a_ready_low, !s_tready, in_valid_reg && out_valid_reg && !m_tready)
    // A request that moves on always yields a result in the next cycle.
    `MZC_ASSERT_NEXT(a_fire_result, fire, out_valid_reg)

endmodule
